// File: rtl/escape_rle_byte_encoder_defines.svh
// Assertion macros for the escape RLE byte encoder.
// No dependencies; included by files that carry concurrent checks.
`ifndef ESCAPE_RLE_BYTE_ENCODER_DEFINES_SVH
`define ESCAPE_RLE_BYTE_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ERLE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("escape rle encoder: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define ERLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("escape rle encoder: next-cycle check failed");

`endif

// File: rtl/erle_pkg.sv
// Package for the escape RLE byte encoder: codes, constants, burst types
// and the run-to-bytes function. No dependencies.
package erle_pkg;

  localparam logic [7:0] ESC_BYTE    = 8'hFF;
  localparam logic [7:0] ESC_ZERO    = 8'h00;
  localparam logic [7:0] MIN_CAP     = 8'd3;
  localparam logic [7:0] MIN_RESET   = 8'd3;
  localparam logic [7:0] MAX_RESET   = 8'd255;
  localparam int         MAX_RESULTS = 8;
  localparam int         CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] REG_MIN_RUN = 8'd0;
  localparam logic [7:0] REG_MAX_RUN = 8'd1;

  typedef logic [MAX_RESULTS-1:0][7:0] burst_t;

  // Bytes of one closed run: byte 0 goes out first, unused bytes are zero.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n;
  } run_emit_t;

  function automatic run_emit_t emit_run(input logic [7:0] value,
                                         input logic [7:0] count,
                                         input logic [7:0] min_cfg);
    run_emit_t  r;
    logic [7:0] min_eff;
    min_eff = (min_cfg > MIN_CAP) ? MIN_CAP : min_cfg;
    r = '0;
    if (count == 8'd0) begin
      r.n = 3'd0;
    end else if (count >= min_eff) begin
      r.bytes[0] = ESC_BYTE;
      r.bytes[1] = count;
      r.bytes[2] = value;
      r.n        = 3'd3;
    end else if (value == ESC_BYTE) begin
      // literal FF goes out as FF 00; a literal run is one or two bytes long
      r.bytes[0] = ESC_BYTE;
      r.bytes[1] = ESC_ZERO;
      if (count[1]) begin
        r.bytes[2] = ESC_BYTE;
        r.bytes[3] = ESC_ZERO;
        r.n        = 3'd4;
      end else begin
        r.n = 3'd2;
      end
    end else begin
      r.bytes[0] = value;
      if (count[1]) begin
        r.bytes[1] = value;
        r.n        = 3'd2;
      end else begin
        r.n = 3'd1;
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/escape_rle_byte_encoder.sv
// Channel   Handshake              Payload
// in        in_valid / in_ready    data_byte[7:0], end_of_stream
// out       out_valid / out_ready  out_byte[7:0], last_of_input, stream_done
// cfg       cfg_valid / cfg_ready  cfg_index[7:0], cfg_data[7:0]
//
// A request causes k encoded bytes (0..8); requests whose run continues give
// 0 bytes and stream in at one per cycle while no burst byte is pending. The
// single output register sends one byte per cycle while out_ready is high.
// Reset (rst, synchronous) clears the run state, the burst count and out_valid
// and loads the register defaults (min 3, max 255). A stalled output holds
// its byte; the input takes a new request while the last burst byte leaves.
// Depends on erle_pkg and escape_rle_byte_encoder_defines.svh.
`include "escape_rle_byte_encoder_defines.svh"

module escape_rle_byte_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_stream,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_input,
  output logic       stream_done,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0] min_run_length;
  logic [7:0] max_run_length;
  logic [7:0] run_value;
  logic [7:0] run_count;
  logic [7:0] run_value_next;
  logic [7:0] run_count_next;

  erle_pkg::burst_t           pend_bytes;
  logic [erle_pkg::CNT_W-1:0] pend_cnt;
  logic                       pend_eos;

  logic                       in_accept;
  logic                       pop;
  logic                       extend;
  logic [7:0]                 grown_count;
  erle_pkg::run_emit_t        close_emit;
  erle_pkg::run_emit_t        flush_emit;
  erle_pkg::burst_t           burst_new;
  logic [erle_pkg::CNT_W-1:0] burst_cnt;

  assign cfg_ready = 1'b1;

  assign pop       = (pend_cnt != '0) && (!out_valid || out_ready);
  assign in_ready  = (pend_cnt == '0) ||
                     ((pend_cnt == erle_pkg::CNT_W'(1)) && pop);
  assign in_accept = in_valid && in_ready;

  // close the held run unless the byte extends it
  assign extend      = (run_count != 8'd0) && (data_byte == run_value) &&
                       (run_count < max_run_length);
  assign grown_count = extend ? (run_count + 8'd1) : 8'd1;

  always_comb begin
    close_emit = erle_pkg::emit_run(run_value, extend ? 8'd0 : run_count,
                                    min_run_length);
    flush_emit = erle_pkg::emit_run(extend ? run_value : data_byte,
                                    end_of_stream ? grown_count : 8'd0,
                                    min_run_length);
    burst_new  = erle_pkg::burst_t'(close_emit.bytes) |
                 (erle_pkg::burst_t'(flush_emit.bytes) << {close_emit.n, 3'b000});
    burst_cnt  = erle_pkg::CNT_W'(close_emit.n) + erle_pkg::CNT_W'(flush_emit.n);
    if (end_of_stream) begin
      run_value_next = 8'd0;
      run_count_next = 8'd0;
    end else begin
      run_value_next = extend ? run_value : data_byte;
      run_count_next = grown_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_run_length <= erle_pkg::MIN_RESET;
      max_run_length <= erle_pkg::MAX_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        erle_pkg::REG_MIN_RUN: min_run_length <= cfg_data;
        erle_pkg::REG_MAX_RUN: max_run_length <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_value <= 8'd0;
      run_count <= 8'd0;
    end else if (in_accept) begin
      run_value <= run_value_next;
      run_count <= run_count_next;
    end
  end

  // burst buffer: byte 0 is next out, shifts down on each pop
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_cnt <= '0;
    end else if (in_accept) begin
      pend_cnt <= burst_cnt;
    end else if (pop) begin
      pend_cnt <= pend_cnt - erle_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pend_bytes <= burst_new;
      pend_eos   <= end_of_stream;
    end else if (pop) begin
      pend_bytes <= pend_bytes >> 8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte      <= pend_bytes[0];
      last_of_input <= (pend_cnt == erle_pkg::CNT_W'(1));
      stream_done   <= (pend_cnt == erle_pkg::CNT_W'(1)) && pend_eos;
    end
  end

  `ERLE_ASSERT_NOW(a_burst_bound, clk, rst, 1'b1,
    pend_cnt <= erle_pkg::CNT_W'(erle_pkg::MAX_RESULTS))
  `ERLE_ASSERT_NEXT(a_eos_clears_run, clk, rst, in_accept && end_of_stream,
    run_count == 8'd0 && run_value == 8'd0)
  `ERLE_ASSERT_NOW(a_done_is_last, clk, rst, out_valid && stream_done,
    last_of_input)
  `ERLE_ASSERT_NEXT(a_stall_holds_burst, clk, rst, out_valid && !out_ready && !in_accept,
    pend_cnt == $past(pend_cnt))

endmodule
